>>> rtl/spectrum_snv_normalizer_assert.svh
// Assertion macros for the spectrum SNV normalizer.
// Included by the top level; no other dependencies.
`ifndef SPECTRUM_SNV_NORMALIZER_ASSERT_SVH
`define SPECTRUM_SNV_NORMALIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define SNV_ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("snv assertion failed");
`define SNV_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("snv forbidden condition");
`else
`define SNV_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define SNV_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> rtl/snv_pkg.sv
// Package for the spectrum SNV normalizer: sizes, widths, state codes.
// No dependencies.
`timescale 1ns / 1ps
package snv_pkg;
    localparam int Bands      = 248;
    localparam int SampleBits = 16;
    localparam int IdxW       = 8;
    localparam int AddrW      = 9;
    localparam int SumW       = 24;
    localparam int SqW        = 40;
    localparam int DW         = 48;
    localparam int RootW      = 32;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_OUT   = 6'b001000,
        ST_LATCH = 6'b010000,
        ST_CALC  = 6'b100000
    } t_state;
endpackage

>>> rtl/snv_stats.sv
// Spectrum statistics unit: mean, variance, root and inverse deviation.
// Depends on snv_pkg. Iterative: one root digit and one quotient bit a cycle.
`timescale 1ns / 1ps
module snv_stats (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [snv_pkg::SumW-1:0]    i_sum,
    input  logic [snv_pkg::SqW-1:0]     i_sq,
    output logic                        o_done,
    output logic [snv_pkg::SumW-1:0]    o_mean,
    output logic [31:0]                 o_inv,
    output logic                        o_flat
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_M1 = 7'b0000010, S_M2 = 7'b0000100,
        S_SQ   = 7'b0001000, S_DV = 7'b0010000, S_FIN = 7'b0100000,
        S_MEAN = 7'b1000000
    } t_sstate;

    localparam logic [63:0] NBands = 64'(snv_pkg::Bands);
    // ceil(2^40 / Bands): exact floor division for any 32-bit numerator
    localparam logic [63:0] MeanRecip = ((64'd1 << 40) + NBands - 64'd1) / NBands;

    t_sstate     r_st;
    logic [63:0] r_a, r_b;     // products
    logic [65:0] r_rem;        // root remainder / division remainder
    logic [63:0] r_v;
    logic [snv_pkg::RootW-1:0] r_root;
    logic [43:0] r_q;
    logic [6:0]  r_cnt;
    logic [63:0] r_num;
    logic [65:0] r_mprod;
    logic        r_done;

    // numerator of the mean, held from start
    logic [31:0] r_mean_num;

    logic [65:0] w_trial;
    logic [65:0] w_rem2;
    logic [64:0] w_drem;

    assign w_rem2  = {r_rem[63:0], r_v[63:62]};
    assign w_trial = {32'd0, r_root, 2'b01};
    assign w_drem  = {r_rem[63:0], r_num[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_done <= 1'b0;
            o_mean <= '0;
            o_inv <= '0;
            o_flat <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_a <= NBands * 64'(i_sq);
                        r_b <= 64'(i_sum) * 64'(i_sum);
                        r_num <= {32'd0, i_sum, 8'd0} + (NBands >> 1);
                        r_st <= S_M1;
                    end
                end
                S_M1: begin
                    r_v <= (r_a - r_b) << 16;
                    o_flat <= (r_a == r_b);
                    r_rem <= '0;
                    r_root <= '0;
                    r_cnt <= '0;
                    r_st <= S_SQ;
                end
                S_SQ: begin
                    if (w_rem2 >= w_trial) begin
                        r_rem <= w_rem2 - w_trial;
                        r_root <= {r_root[snv_pkg::RootW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2;
                        r_root <= {r_root[snv_pkg::RootW-2:0], 1'b0};
                    end
                    r_v <= r_v << 2;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd31) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_q <= '0;
                        r_num <= NBands << 55;
                        r_st <= S_M2;
                    end
                end
                S_M2: begin
                    r_st <= S_DV;
                end
                S_DV: begin
                    // n<<35 over root, one bit per cycle (44 bits)
                    if (w_drem >= 65'(r_root)) begin
                        r_rem <= 66'(w_drem - 65'(r_root));
                        r_q <= {r_q[42:0], 1'b1};
                    end else begin
                        r_rem <= 66'(w_drem);
                        r_q <= {r_q[42:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd43) r_st <= S_FIN;
                end
                S_FIN: begin
                    if (o_flat || r_root == '0) o_inv <= '0;
                    else if (r_q[43:32] != '0) o_inv <= 32'hFFFF_FFFF;
                    else o_inv <= r_q[31:0];
                    r_mprod <= 66'(r_mean_num) * 66'(MeanRecip);
                    r_st <= S_MEAN;
                end
                S_MEAN: begin
                    o_mean <= r_mprod[snv_pkg::SumW+39:40];
                    r_done <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_start)
            r_mean_num <= {i_sum, 8'd0} + 32'(snv_pkg::Bands / 2);
    end

    assign o_done = r_done;
endmodule

>>> rtl/spectrum_snv_normalizer.sv
// Latency: one spectrum; a band goes out in the last step of the item that emits it.
// Items: one at a time, each through accept, memory read, difference, multiply,
// round; a result still waiting on the output holds the next item in its last step.
// On the last band of a spectrum the statistics unit runs before the next item
// is taken (32-step root, 44-step reciprocal, reciprocal-multiply mean).
// Reset: synchronous active-low i_rst_n clears control state and sums, not the memory.
`timescale 1ns / 1ps
`include "spectrum_snv_normalizer_assert.svh"
module spectrum_snv_normalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tuser,   // [0] drain
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] norm_value, [23:16] band_index
    output logic        m_axis_tlast,   // last_band
    output logic        m_axis_tuser    // flat_spectrum
);
    snv_pkg::t_state r_st;

    logic [snv_pkg::SampleBits-1:0] r_mem [0:2*snv_pkg::Bands-1];
    logic [snv_pkg::SampleBits-1:0] r_rd;

    logic [snv_pkg::SumW-1:0] r_sum;
    logic [snv_pkg::SqW-1:0]  r_sq;
    logic [snv_pkg::IdxW-1:0] r_load_cnt, r_emit_cnt;
    logic r_load_bank, r_held_valid, r_held_flat;
    logic [snv_pkg::SumW-1:0] r_mean;
    logic [31:0] r_inv;

    logic r_drain, r_emit;
    logic [snv_pkg::SampleBits-1:0] r_x;
    logic r_neg;
    logic [snv_pkg::SumW:0] r_mag;
    logic [56:0] r_prod;
    logic [snv_pkg::IdxW-1:0] r_oidx;
    logic r_olast, r_oflat;

    logic [snv_pkg::SumW-1:0] w_mean;
    logic [31:0] w_inv;
    logic w_flat, w_done, r_start;

    logic w_last_load;
    logic [snv_pkg::AddrW-1:0] w_rd_addr, w_wr_addr;
    logic signed [snv_pkg::SumW+1:0] w_diff;
    logic [33:0] w_q;
    logic [15:0] w_val;

    assign s_axis_tready = (r_st == snv_pkg::ST_IDLE);
    assign w_last_load = (r_load_cnt == snv_pkg::IdxW'(snv_pkg::Bands - 1));
    assign w_rd_addr = r_load_bank ? snv_pkg::AddrW'(r_emit_cnt)
                                   : snv_pkg::AddrW'(r_emit_cnt) +
                                     snv_pkg::AddrW'(snv_pkg::Bands);
    assign w_wr_addr = r_load_bank ? snv_pkg::AddrW'(r_load_cnt) +
                                     snv_pkg::AddrW'(snv_pkg::Bands)
                                   : snv_pkg::AddrW'(r_load_cnt);
    assign w_diff = $signed({2'b00, r_rd, 8'd0}) - $signed({2'b00, r_mean});
    assign w_q = 34'((r_prod + 57'd8388608) >> 24);

    always_comb begin
        if (r_oflat) w_val = '0;
        else if (r_neg) w_val = (w_q > 34'd32768) ? 16'h8000 : 16'(-w_q[16:0]);
        else w_val = (w_q > 34'd32767) ? 16'h7FFF : w_q[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready && !s_axis_tuser)
            r_mem[w_wr_addr] <= s_axis_tdata;
        r_rd <= r_mem[w_rd_addr];
    end

    snv_stats u_stats (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_sum(r_sum), .i_sq(r_sq), .o_done(w_done),
        .o_mean(w_mean), .o_inv(w_inv), .o_flat(w_flat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= snv_pkg::ST_IDLE;
            r_sum <= '0; r_sq <= '0;
            r_load_cnt <= '0; r_emit_cnt <= '0;
            r_load_bank <= 1'b0; r_held_valid <= 1'b0; r_held_flat <= 1'b0;
            r_mean <= '0; r_inv <= '0;
            r_start <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (m_axis_tvalid && m_axis_tready &&
                !(r_st == snv_pkg::ST_LATCH && r_emit)) m_axis_tvalid <= 1'b0;
            unique case (r_st)
                snv_pkg::ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_drain <= s_axis_tuser;
                        r_x <= s_axis_tdata;
                        r_emit <= r_held_valid;
                        r_st <= snv_pkg::ST_READ;
                    end
                end
                snv_pkg::ST_READ: r_st <= snv_pkg::ST_MUL;
                snv_pkg::ST_MUL: begin
                    r_neg <= w_diff < 0;
                    r_mag <= (w_diff < 0) ? 25'(-w_diff) : 25'(w_diff);
                    r_oidx <= r_emit_cnt;
                    r_olast <= (r_emit_cnt == snv_pkg::IdxW'(snv_pkg::Bands - 1));
                    r_oflat <= r_held_flat;
                    r_st <= snv_pkg::ST_OUT;
                end
                snv_pkg::ST_OUT: begin
                    r_prod <= 57'(r_mag) * 57'(r_inv);
                    r_st <= snv_pkg::ST_LATCH;
                end
                snv_pkg::ST_LATCH: begin
                    if (!r_emit || !m_axis_tvalid || m_axis_tready) begin
                        if (r_emit) begin
                            m_axis_tvalid <= 1'b1;
                            m_axis_tdata <= {r_oidx, w_val};
                            m_axis_tlast <= r_olast;
                            m_axis_tuser <= r_oflat;
                            if (r_olast) begin
                                r_held_valid <= 1'b0;
                                r_emit_cnt <= '0;
                            end else begin
                                r_emit_cnt <= r_emit_cnt + 1'b1;
                            end
                        end
                        r_st <= snv_pkg::ST_IDLE;
                        if (!r_drain) begin
                            if (w_last_load) begin
                                r_start <= 1'b1;
                                r_st <= snv_pkg::ST_CALC;
                            end else begin
                                r_sum <= r_sum + snv_pkg::SumW'(r_x);
                                r_sq <= r_sq + snv_pkg::SqW'(r_x) * snv_pkg::SqW'(r_x);
                                r_load_cnt <= r_load_cnt + 1'b1;
                            end
                            if (w_last_load) begin
                                r_sum <= r_sum + snv_pkg::SumW'(r_x);
                                r_sq <= r_sq + snv_pkg::SqW'(r_x) * snv_pkg::SqW'(r_x);
                            end
                        end
                    end
                end
                snv_pkg::ST_CALC: begin
                    if (w_done) begin
                        r_mean <= w_mean; r_inv <= w_inv; r_held_flat <= w_flat;
                        r_held_valid <= 1'b1; r_emit_cnt <= '0;
                        r_load_bank <= ~r_load_bank; r_load_cnt <= '0;
                        r_sum <= '0; r_sq <= '0;
                        r_st <= snv_pkg::ST_IDLE;
                    end
                end
                default: r_st <= snv_pkg::ST_IDLE;
            endcase
        end
    end

    `SNV_ASSERT_NEVER(a_no_accept_busy, i_clk, i_rst_n, s_axis_tready && r_st != snv_pkg::ST_IDLE)
    `SNV_ASSERT_IMPL(a_done_in_calc, i_clk, i_rst_n, w_done |-> r_st == snv_pkg::ST_CALC)
    `SNV_ASSERT_IMPL(a_flat_zero, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[15:0] == 16'd0)
endmodule
